// File: hw/rtl/rcm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RTMP chunk muxer package
// Request and result types, the job passed from front to back, and the
// chunk header constants shared by the muxer modules.
// ----------------------------------------------------------------------------
package rcm_pkg;

  localparam int JOB_BYTES = 18;

  localparam logic       OP_HEADER  = 1'b0;
  localparam logic       OP_PAYLOAD = 1'b1;

  localparam logic [1:0] FMT_FULL   = 2'd0;
  localparam logic [1:0] FMT_NO_MSID = 2'd1;
  localparam logic [1:0] FMT_DELTA  = 2'd2;
  localparam logic [1:0] FMT_CONT   = 2'd3;

  localparam logic [16:0] CSID_ONE_MAX = 17'd63;
  localparam logic [16:0] CSID_TWO_MAX = 17'd319;
  localparam logic [16:0] CSID_OFFSET  = 17'd64;
  localparam logic [7:0]  CSID_MASK    = 8'h3F;
  localparam logic [7:0]  CSID_THREE_MARK = 8'h01;

  localparam logic [23:0] CHUNK_RESET = 24'd128;

  typedef struct packed {
    logic        operation;
    logic [1:0]  chunk_format;
    logic [16:0] chunk_stream;
    logic [23:0] time_field;
    logic [23:0] message_length;
    logic [7:0]  message_type;
    logic [31:0] message_stream;
    logic        has_extended_time;
    logic [31:0] extended_time;
    logic [23:0] payload_bytes;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_header;
    logic       run_last;
    logic       chunk_end;
    logic       message_end;
    logic       stray_byte;
  } result_t;

  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;
    logic [4:0]                count;
    logic [4:0]                hdr_count;
    logic                      chunk_end;
    logic                      message_end;
    logic                      stray;
  } job_t;

endpackage
`default_nettype wire

// File: hw/rtl/rcm_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RTMP chunk muxer front end
// Accepts requests, tracks the open message and chunk fill, and turns each
// request into a job holding its header bytes, payload byte and flags.
// ----------------------------------------------------------------------------
module rcm_front (
  input  logic           clk,
  input  logic           rst,
  input  logic [23:0]    chunk_limit,
  input  logic           item_valid,
  output logic           item_ready,
  input  rcm_pkg::item_t item,
  output logic           job_valid,
  input  logic           job_ready,
  output rcm_pkg::job_t  job
);
  import rcm_pkg::*;

  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      len;
  } basic_t;

  function automatic basic_t basic_header(input logic [1:0] fmt, input logic [16:0] cs);
    basic_t      b;
    logic [16:0] off;
    logic [7:0]  b0;
    off = cs - CSID_OFFSET;
    b0  = {fmt, 6'd0};
    b.bytes = '0;
    if (cs <= CSID_ONE_MAX) begin
      b.bytes[0] = b0 | (cs[7:0] & CSID_MASK);
      b.len      = 2'd1;
    end else if (cs <= CSID_TWO_MAX) begin
      b.bytes[0] = b0;
      b.bytes[1] = off[7:0];
      b.len      = 2'd2;
    end else begin
      b.bytes[0] = b0 | CSID_THREE_MARK;
      b.bytes[1] = off[7:0];
      b.bytes[2] = off[15:8];
      b.len      = 2'd3;
    end
    return b;
  endfunction

  logic        message_open;
  logic [23:0] bytes_remaining;
  logic [23:0] bytes_in_chunk;
  logic [16:0] saved_stream;

  logic             accept;
  basic_t           hb;
  basic_t           cb;
  logic [10:0][7:0] mh;
  logic [3:0][7:0]  ext;
  logic [3:0]       mlen;
  logic [4:0]       hdr_total;
  logic [4:0]       cont_len;
  logic             need_cont;
  logic [23:0]      bic_base;
  logic [23:0]      bic_inc;
  logic [23:0]      rem_dec;
  logic [4:0]       k;
  logic [4:0]       m;

  assign job_valid  = item_valid;
  assign item_ready = job_ready;
  assign accept     = item_valid && job_ready;

  always_comb begin
    hb  = basic_header(item.chunk_format, item.chunk_stream);
    cb  = basic_header(FMT_CONT, saved_stream);
    mh[0]  = item.time_field[23:16];
    mh[1]  = item.time_field[15:8];
    mh[2]  = item.time_field[7:0];
    mh[3]  = item.message_length[23:16];
    mh[4]  = item.message_length[15:8];
    mh[5]  = item.message_length[7:0];
    mh[6]  = item.message_type;
    mh[7]  = item.message_stream[7:0];
    mh[8]  = item.message_stream[15:8];
    mh[9]  = item.message_stream[23:16];
    mh[10] = item.message_stream[31:24];
    ext[0] = item.extended_time[31:24];
    ext[1] = item.extended_time[23:16];
    ext[2] = item.extended_time[15:8];
    ext[3] = item.extended_time[7:0];
    unique case (item.chunk_format)
      FMT_FULL:    mlen = 4'd11;
      FMT_NO_MSID: mlen = 4'd7;
      FMT_DELTA:   mlen = 4'd3;
      FMT_CONT:    mlen = 4'd0;
      default:     mlen = 4'd0;
    endcase
    hdr_total = 5'(hb.len) + 5'(mlen) + (item.has_extended_time ? 5'd4 : 5'd0);

    need_cont = bytes_in_chunk >= chunk_limit;
    bic_base  = need_cont ? 24'd0 : bytes_in_chunk;
    bic_inc   = bic_base + 24'd1;
    rem_dec   = bytes_remaining - 24'd1;
    cont_len  = need_cont ? 5'(cb.len) : 5'd0;

    job = '0;
    k   = '0;
    m   = '0;
    if (item.operation == OP_HEADER) begin
      job.count       = hdr_total;
      job.hdr_count   = hdr_total;
      job.chunk_end   = item.payload_bytes == 24'd0;
      job.message_end = item.payload_bytes == 24'd0;
      for (int i = 0; i < JOB_BYTES; i++) begin
        k = 5'(i) - 5'(hb.len);
        m = k - 5'(mlen);
        if (5'(i) < 5'(hb.len)) begin
          job.bytes[i] = hb.bytes[2'(i)];
        end else if (k < 5'(mlen)) begin
          job.bytes[i] = mh[4'(k)];
        end else begin
          job.bytes[i] = ext[2'(m)];
        end
      end
    end else if (!message_open) begin
      job.count    = 5'd1;
      job.bytes[0] = item.data_byte;
      job.stray    = 1'b1;
    end else begin
      job.count       = cont_len + 5'd1;
      job.hdr_count   = cont_len;
      job.message_end = rem_dec == 24'd0;
      job.chunk_end   = (rem_dec == 24'd0) || (bic_inc >= chunk_limit);
      for (int i = 0; i < 4; i++) begin
        job.bytes[i] = (5'(i) < cont_len) ? cb.bytes[2'(i)] : item.data_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      message_open    <= 1'b0;
      bytes_remaining <= '0;
      bytes_in_chunk  <= '0;
      saved_stream    <= '0;
    end else if (accept) begin
      if (item.operation == OP_HEADER) begin
        saved_stream    <= item.chunk_stream;
        bytes_in_chunk  <= '0;
        bytes_remaining <= item.payload_bytes;
        message_open    <= item.payload_bytes != 24'd0;
      end else if (message_open) begin
        bytes_in_chunk  <= bic_inc;
        bytes_remaining <= rem_dec;
        if (rem_dec == 24'd0) begin
          message_open <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/rcm_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RTMP chunk muxer job queue
// Two-entry queue that decouples the front end from the byte serializer.
// ----------------------------------------------------------------------------
module rcm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  rcm_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop_ready,
  output rcm_pkg::job_t pop_job
);
  import rcm_pkg::*;

  job_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = count != 2'd2;
  assign pop_valid  = count != 2'd0;
  assign pop_job    = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/rcm_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RTMP chunk muxer byte serializer
// Walks the bytes of the job at the head of the queue, one per cycle while
// the result side is not stalled, into a registered result stage.
// ----------------------------------------------------------------------------
module rcm_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  output logic             job_ready,
  input  rcm_pkg::job_t    job,
  output logic             result_valid,
  input  logic             result_ready,
  output rcm_pkg::result_t result
);
  import rcm_pkg::*;

  logic [4:0] idx;
  logic       load;
  logic       last;

  assign load      = !result_valid || result_ready;
  assign last      = idx == (job.count - 5'd1);
  assign job_ready = load && job_valid && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      idx          <= '0;
    end else if (load) begin
      result_valid <= job_valid;
      if (job_valid) begin
        idx <= last ? 5'd0 : idx + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && job_valid) begin
      result.out_byte    <= job.bytes[idx];
      result.is_header   <= idx < job.hdr_count;
      result.run_last    <= last;
      result.chunk_end   <= last && job.chunk_end;
      result.message_end <= last && job.message_end;
      result.stray_byte  <= job.stray;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/rtmp_chunk_muxer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RTMP chunk muxer
// Serializes message header requests and payload bytes into an RTMP chunk
// stream, one byte per result.
// ----------------------------------------------------------------------------
// The block emits one stream byte per clock cycle, while the result side
// does not stall, through a registered output stage. A request produces
// one byte for a payload byte or a stray byte, two to four for a payload
// byte that opens a new chunk with a type 3 header, and one to eighteen
// for a message header request. The byte serializer sets the output rate;
// a two-entry queue lets the front end take the next request while bytes
// of earlier ones are still going out, and the first byte of a request
// passes the queue and the registered result stage on its way out. The
// chunk size register resets to 128, and a value of zero acts as one.
module rtmp_chunk_muxer (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [23:0]      cfg_data,
  input  logic             item_valid,
  output logic             item_ready,
  input  rcm_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output rcm_pkg::result_t result
);
  import rcm_pkg::*;

  logic [23:0] chunk_limit;
  logic        fj_valid;
  logic        fj_ready;
  job_t        fj;
  logic        bj_valid;
  logic        bj_ready;
  job_t        bj;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_limit <= CHUNK_RESET;
    end else if (cfg_write) begin
      chunk_limit <= (cfg_data == 24'd0) ? 24'd1 : cfg_data;
    end
  end

  rcm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .chunk_limit (chunk_limit),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .job_valid   (fj_valid),
    .job_ready   (fj_ready),
    .job         (fj)
  );

  rcm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fj_valid),
    .push_ready (fj_ready),
    .push_job   (fj),
    .pop_valid  (bj_valid),
    .pop_ready  (bj_ready),
    .pop_job    (bj)
  );

  rcm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (bj_valid),
    .job_ready    (bj_ready),
    .job          (bj),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTMP chunk muxer testbench
// Drives header and payload requests into the muxer and checks every stream
// byte and flag against a chunk serializer kept inside the testbench. Random
// gaps on the request side and random stalls on the result side are used,
// and the chunk size register goes through its extremes.
// ----------------------------------------------------------------------------
module tb;
  import rcm_pkg::*;

  localparam int FILL_ZERO   = 0;
  localparam int FILL_ONES   = 1;
  localparam int FILL_RANDOM = 2;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [23:0] cfg_data = '0;
  logic        item_valid = 1'b0;
  logic        item_ready;
  item_t       item = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  result_t     result;

  logic [23:0] chunk_limit = CHUNK_RESET;
  logic        msg_open = 1'b0;
  logic [23:0] left_in_msg = '0;
  logic [23:0] chunk_fill = '0;
  logic [16:0] open_stream = '0;
  result_t     run_bytes[$];
  result_t     stream_bytes_due[$];

  int  mismatches = 0;
  int  requests_sent = 0;
  int  bytes_checked = 0;
  int  size_settings = 0;
  int  stall_left = 0;
  bit  quiet = 1'b0;

  rtmp_chunk_muxer i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int gap_length();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [16:0] pick_stream();
    logic [16:0] cs;
    case ($urandom_range(0, 3))
      0: cs = 17'($urandom_range(0, 63));
      1: cs = 17'($urandom_range(64, 319));
      2: cs = 17'($urandom_range(320, 65599));
      default: cs = 17'($urandom);
    endcase
    return cs;
  endfunction

  function automatic item_t header_item(input logic [1:0] fmt, input logic [16:0] cs,
                                        input logic [23:0] pay, input int fill);
    item_t        it;
    logic [191:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = noise[$bits(item_t)-1:0];
    if (fill == FILL_ZERO) begin
      it = '0;
    end else if (fill == FILL_ONES) begin
      it = '1;
    end
    it.operation     = OP_HEADER;
    it.chunk_format  = fmt;
    it.chunk_stream  = cs;
    it.payload_bytes = pay;
    return it;
  endfunction

  function automatic item_t payload_item(input logic [7:0] d);
    item_t        it;
    logic [191:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = noise[$bits(item_t)-1:0];
    it.operation = OP_PAYLOAD;
    it.data_byte = d;
    return it;
  endfunction

  task automatic add_byte(input logic [7:0] b, input logic hdr);
    result_t r;
    r = '0;
    r.out_byte  = b;
    r.is_header = hdr;
    run_bytes.push_back(r);
  endtask

  task automatic add_be24(input logic [23:0] v);
    add_byte(v[23:16], 1'b1);
    add_byte(v[15:8], 1'b1);
    add_byte(v[7:0], 1'b1);
  endtask

  task automatic add_basic(input logic [1:0] fmt, input logic [16:0] cs);
    logic [16:0] v;
    logic [7:0]  b0;
    v  = cs - CSID_OFFSET;
    b0 = {fmt, 6'd0};
    if (cs <= CSID_ONE_MAX) begin
      add_byte(b0 | (cs[7:0] & CSID_MASK), 1'b1);
    end else if (cs <= CSID_TWO_MAX) begin
      add_byte(b0, 1'b1);
      add_byte(v[7:0], 1'b1);
    end else begin
      add_byte(b0 | CSID_THREE_MARK, 1'b1);
      add_byte(v[7:0], 1'b1);
      add_byte(v[15:8], 1'b1);
    end
  endtask

  task automatic serialize_request(input item_t req);
    logic [23:0] lim;
    result_t     tail;
    logic        end_chunk;
    logic        end_msg;
    logic        stray;
    lim = (chunk_limit == '0) ? 24'd1 : chunk_limit;
    end_chunk = 1'b0;
    end_msg   = 1'b0;
    stray     = 1'b0;
    if (req.operation == OP_HEADER) begin
      add_basic(req.chunk_format, req.chunk_stream);
      if (req.chunk_format != FMT_CONT) begin
        add_be24(req.time_field);
      end
      if (req.chunk_format == FMT_FULL || req.chunk_format == FMT_NO_MSID) begin
        add_be24(req.message_length);
        add_byte(req.message_type, 1'b1);
      end
      if (req.chunk_format == FMT_FULL) begin
        add_byte(req.message_stream[7:0], 1'b1);
        add_byte(req.message_stream[15:8], 1'b1);
        add_byte(req.message_stream[23:16], 1'b1);
        add_byte(req.message_stream[31:24], 1'b1);
      end
      if (req.has_extended_time) begin
        add_byte(req.extended_time[31:24], 1'b1);
        add_byte(req.extended_time[23:16], 1'b1);
        add_byte(req.extended_time[15:8], 1'b1);
        add_byte(req.extended_time[7:0], 1'b1);
      end
      open_stream = req.chunk_stream;
      chunk_fill  = '0;
      left_in_msg = req.payload_bytes;
      msg_open    = (req.payload_bytes != '0);
      end_chunk   = (req.payload_bytes == '0);
      end_msg     = end_chunk;
    end else if (!msg_open) begin
      add_byte(req.data_byte, 1'b0);
      stray = 1'b1;
    end else begin
      if (chunk_fill >= lim) begin
        add_basic(FMT_CONT, open_stream);
        chunk_fill = '0;
      end
      add_byte(req.data_byte, 1'b0);
      chunk_fill  = chunk_fill + 24'd1;
      left_in_msg = left_in_msg - 24'd1;
      if (left_in_msg == '0) begin
        end_chunk = 1'b1;
        end_msg   = 1'b1;
        msg_open  = 1'b0;
      end else if (chunk_fill >= lim) begin
        end_chunk = 1'b1;
      end
    end
    tail = run_bytes.pop_back();
    tail.run_last    = 1'b1;
    tail.chunk_end   = end_chunk;
    tail.message_end = end_msg;
    tail.stray_byte  = stray;
    run_bytes.push_back(tail);
    while (run_bytes.size() != 0) begin
      stream_bytes_due.push_back(run_bytes.pop_front());
    end
  endtask

  task automatic send_request(input item_t req);
    int gap;
    gap = (quiet || $urandom_range(0, 99) < 55) ? 0 : gap_length();
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= req;
    do @(posedge clk); while (item_ready !== 1'b1);
    serialize_request(req);
    requests_sent++;
  endtask

  task automatic send_payload(input int count);
    repeat (count) send_request(payload_item(8'($urandom)));
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (stream_bytes_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_chunk_size(input logic [23:0] v);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write   <= 1'b0;
    chunk_limit = v;
    size_settings++;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid === 1'b1 && result_ready) begin
      if (stream_bytes_due.size() == 0) begin
        $error("Result byte %0h arrived with nothing expected.", result.out_byte);
        mismatches++;
      end else begin
        want = stream_bytes_due.pop_front();
        check_field("out_byte", want.out_byte, result.out_byte);
        check_field("is_header", 8'(want.is_header), 8'(result.is_header));
        check_field("run_last", 8'(want.run_last), 8'(result.run_last));
        check_field("chunk_end", 8'(want.chunk_end), 8'(result.chunk_end));
        check_field("message_end", 8'(want.message_end), 8'(result.message_end));
        check_field("stray_byte", 8'(want.stray_byte), 8'(result.stray_byte));
        bytes_checked++;
      end
    end
    if (stall_left != 0) begin
      result_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (!quiet && $urandom_range(0, 99) < 25) begin
      result_ready <= 1'b0;
      stall_left = gap_length() - 1;
    end else begin
      result_ready <= 1'b1;
    end
  end

  task automatic test_stray_bytes();
    send_request(payload_item(8'h00));
    send_request(payload_item(8'hFF));
    drain();
  endtask

  task automatic test_default_chunk();
    send_request(header_item(FMT_FULL, 17'd5, 24'd129, FILL_RANDOM));
    send_payload(129);
    drain();
  endtask

  task automatic test_header_forms();
    send_request(header_item(FMT_FULL, 17'd0, 24'd0, FILL_ZERO));
    send_request(header_item(FMT_NO_MSID, 17'd1, 24'd0, FILL_RANDOM));
    send_request(header_item(FMT_DELTA, 17'd63, 24'd0, FILL_RANDOM));
    send_request(header_item(FMT_CONT, 17'd64, 24'd0, FILL_ONES));
    send_request(header_item(FMT_FULL, 17'd319, 24'd0, FILL_ONES));
    send_request(header_item(FMT_NO_MSID, 17'd320, 24'd0, FILL_RANDOM));
    send_request(header_item(FMT_DELTA, 17'd65599, 24'd0, FILL_RANDOM));
    send_request(header_item(FMT_CONT, 17'h1FFFF, 24'd0, FILL_ONES));
    send_request(header_item(FMT_FULL, 17'd65600, 24'd0, FILL_ONES));
    drain();
  endtask

  task automatic test_chunk_extremes();
    set_chunk_size(24'd1);
    send_request(header_item(FMT_FULL, 17'd400, 24'd3, FILL_RANDOM));
    send_payload(3);
    drain();
    set_chunk_size(24'd0);
    send_request(header_item(FMT_DELTA, 17'd10, 24'd2, FILL_RANDOM));
    send_payload(2);
    drain();
    set_chunk_size(24'hFFFFFF);
    send_request(header_item(FMT_NO_MSID, 17'd70000, 24'd3, FILL_RANDOM));
    send_payload(3);
    drain();
  endtask

  task automatic test_abandoned_message();
    send_request(header_item(FMT_FULL, 17'd200, 24'hFFFFFF, FILL_RANDOM));
    send_payload(2);
    send_request(header_item(FMT_NO_MSID, 17'd7, 24'd1, FILL_RANDOM));
    send_payload(1);
    drain();
  endtask

  task automatic test_live_resize();
    set_chunk_size(24'd4);
    send_request(header_item(FMT_FULL, 17'd90, 24'd8, FILL_RANDOM));
    send_payload(6);
    drain();
    set_chunk_size(24'd2);
    send_payload(2);
    drain();
  endtask

  task automatic test_random_traffic();
    int start;
    int n;
    int cut;
    int r;
    logic [23:0] size;
    start = requests_sent;
    while (requests_sent - start < 12) begin
      case ($urandom_range(0, 6))
        0: size = 24'd1;
        1: size = 24'd2;
        2: size = 24'd3;
        3: size = 24'd0;
        4: size = 24'hFFFFFF;
        default: size = 24'($urandom_range(4, 9));
      endcase
      set_chunk_size(size);
      quiet = ($urandom_range(0, 2) == 0);
      repeat (4) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          n = $urandom_range(0, 12);
          send_request(header_item(2'($urandom_range(0, 3)), pick_stream(), 24'(n),
                                   FILL_RANDOM));
          send_payload(n);
        end else if (r < 90) begin
          send_request(payload_item(8'($urandom)));
        end else begin
          n   = $urandom_range(2, 12);
          cut = $urandom_range(0, n - 1);
          send_request(header_item(2'($urandom_range(0, 3)), pick_stream(), 24'(n),
                                   FILL_RANDOM));
          send_payload(cut);
        end
      end
      drain();
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_stray_bytes();
    test_default_chunk();
    test_header_forms();
    test_chunk_extremes();
    test_abandoned_message();
    test_live_resize();
    test_random_traffic();
    drain();
    repeat (20) @(posedge clk);
    $display("Sent %0d requests and checked %0d stream bytes under %0d chunk size settings.",
             requests_sent, bytes_checked, size_settings);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timed out with %0d stream bytes still expected.", stream_bytes_due.size());
    $display("tb NOT OK");
    $finish;
  end

endmodule
